[rtl/mru_pkg.sv]
package mru_pkg;

    // Field widths fixed by the word format
    localparam int POINT_W = 64;
    localparam int NAME_W  = 16;
    localparam int POS_W   = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic upd;
    } t_cell_ctl;

endpackage

[rtl/mru_cell.sv]
module mru_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mru_pkg::t_cell_ctl            i_ctl,
    input  logic [mru_pkg::POINT_W-1:0]   i_key,
    input  logic [mru_pkg::POS_W-1:0]     i_index,
    input  logic [mru_pkg::POINT_W-1:0]   i_prev_point,
    input  logic [mru_pkg::NAME_W-1:0]    i_prev_name,
    input  logic                          i_prev_valid,
    input  logic                          i_hit_above,
    input  logic [mru_pkg::POS_W-1:0]     i_pos_above,
    output logic [mru_pkg::POINT_W-1:0]   o_point,
    output logic [mru_pkg::NAME_W-1:0]    o_name,
    output logic                          o_valid,
    output logic                          o_match,
    output logic                          o_hit_below,
    output logic [mru_pkg::POS_W-1:0]     o_pos_below
);
    import mru_pkg::*;

    logic [POINT_W-1:0] r_point;
    logic [NAME_W-1:0]  r_name;
    logic               r_valid;
    logic               r_match;

    // Compare the stored key against the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= r_valid && (r_point == i_key);
        end
    end

    // Take the neighbor's entry unless a hit sits closer to the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.upd && !i_hit_above) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && !i_hit_above) begin
            r_point <= i_prev_point;
            r_name  <= i_prev_name;
        end
    end

    // Pass the hit flag and hit position down the chain
    assign o_hit_below = i_hit_above | r_match;
    assign o_pos_below = i_pos_above | (r_match ? i_index : '0);

    assign o_point = r_point;
    assign o_name  = r_name;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

[rtl/mru_move_to_front_list.sv]
// Accepted words are registered, compared across all cells in the compare state, and in
// the update state the output register is loaded; on an add, each cell up to and including
// a hit cell takes its neighbor's entry. No new word is accepted until the update ends.
// A held result does not block acceptance, but a stalled output register holds the update.
// Reset (synchronous, active low) empties the list at once; no clearing pass is run.
module mru_move_to_front_list #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [mru_pkg::POINT_W-1:0]   i_point_code,
    input  logic [mru_pkg::NAME_W-1:0]    i_name_handle,
    input  logic [mru_pkg::POS_W-1:0]     i_position,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [mru_pkg::POS_W-1:0]     o_hit_position,
    output logic                          o_evicted,
    output logic [mru_pkg::POINT_W-1:0]   o_evicted_point,
    output logic [mru_pkg::NAME_W-1:0]    o_evicted_name,
    output logic                          o_read_valid,
    output logic [mru_pkg::POINT_W-1:0]   o_read_point,
    output logic [mru_pkg::NAME_W-1:0]    o_read_name,
    output logic [mru_pkg::COUNT_W-1:0]   o_entry_count
);
    import mru_pkg::*;

    localparam int FILL_W    = $clog2(MAX_ENTRIES + 1);
    localparam int READ_SPAN = 1 << POS_W;

    t_state             r_state;
    t_state             n_state;
    t_cell_ctl          w_ctl;
    logic               w_go;
    logic               w_accept;

    t_op                r_op;
    logic [POINT_W-1:0] r_key;
    logic [NAME_W-1:0]  r_name;
    logic [POS_W-1:0]   r_pos;

    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;

    logic [POINT_W-1:0] w_point [MAX_ENTRIES];
    logic [NAME_W-1:0]  w_name  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_hit_chain;
    logic [POS_W-1:0]   w_pos_chain [MAX_ENTRIES];

    logic               w_hit;
    logic               w_full;
    logic               w_evict;
    logic               w_rd_valid;
    logic [POINT_W-1:0] w_rd_point;
    logic [NAME_W-1:0]  w_rd_name;
    logic [POINT_W-1:0] w_front_point;

    logic               r_out_valid;
    logic               r_hit;
    logic [POS_W-1:0]   r_hit_pos;
    logic               r_evicted;
    logic [POINT_W-1:0] r_ev_point;
    logic [NAME_W-1:0]  r_ev_name;
    logic               r_rd_valid;
    logic [POINT_W-1:0] r_rd_point;
    logic [NAME_W-1:0]  r_rd_name;
    logic [COUNT_W-1:0] r_count;

    assign w_accept = i_valid && !o_stall;
    assign w_go     = (r_state == S_UPD) && (!r_out_valid || !i_stall);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_ctl   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_CMP:   w_ctl.cmp = 1'b1;
            S_UPD:   w_ctl.upd = w_go && (r_op == OP_ADD);
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_op);
            r_key <= i_point_code;
            r_name <= i_name_handle;
            r_pos <= i_position;
        end
    end

    // Chain of entry cells, front at index 0
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [POINT_W-1:0] w_prev_point;
        logic [NAME_W-1:0]  w_prev_name;
        logic               w_prev_valid;
        logic               w_hit_above;
        logic [POS_W-1:0]   w_pos_above;

        if (g == 0) begin : g_front
            assign w_prev_point = r_key;
            assign w_prev_name  = r_name;
            assign w_prev_valid = 1'b1;
            assign w_hit_above  = 1'b0;
            assign w_pos_above  = '0;
        end else begin : g_rest
            assign w_prev_point = w_point[g-1];
            assign w_prev_name  = w_name[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_hit_above  = w_hit_chain[g-1];
            assign w_pos_above  = w_pos_chain[g-1];
        end

        mru_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_index      (POS_W'(g)),
            .i_prev_point (w_prev_point),
            .i_prev_name  (w_prev_name),
            .i_prev_valid (w_prev_valid),
            .i_hit_above  (w_hit_above),
            .i_pos_above  (w_pos_above),
            .o_point      (w_point[g]),
            .o_name       (w_name[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_hit_below  (w_hit_chain[g]),
            .o_pos_below  (w_pos_chain[g])
        );
    end

    assign w_front_point = w_point[0];

    // Resolve the add outcome
    assign w_hit   = w_hit_chain[MAX_ENTRIES-1];
    assign w_full  = (r_fill == FILL_W'(MAX_ENTRIES));
    assign w_evict = !w_hit && w_full;
    assign n_fill  = (r_op == OP_ADD && !w_hit && !w_full) ? r_fill + FILL_W'(1) : r_fill;

    // Select the entry at the read position
    always_comb begin
        w_rd_valid = 1'b0;
        w_rd_point = '0;
        w_rd_name  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i < READ_SPAN && r_pos == POS_W'(i) && w_valid[i]) begin
                w_rd_valid = 1'b1;
                w_rd_point = w_point[i];
                w_rd_name  = w_name[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_go) begin
            r_fill <= n_fill;
        end
    end

    // Output register: load on update, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_count <= COUNT_W'(n_fill);
            if (r_op == OP_ADD) begin
                r_hit      <= w_hit;
                r_hit_pos  <= w_pos_chain[MAX_ENTRIES-1];
                r_evicted  <= w_evict;
                r_ev_point <= w_evict ? w_point[MAX_ENTRIES-1] : '0;
                r_ev_name  <= w_evict ? w_name[MAX_ENTRIES-1] : '0;
                r_rd_valid <= 1'b0;
                r_rd_point <= '0;
                r_rd_name  <= '0;
            end else begin
                r_hit      <= 1'b0;
                r_hit_pos  <= '0;
                r_evicted  <= 1'b0;
                r_ev_point <= '0;
                r_ev_name  <= '0;
                r_rd_valid <= w_rd_valid;
                r_rd_point <= w_rd_point;
                r_rd_name  <= w_rd_name;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_hit_position  = r_hit_pos;
    assign o_evicted       = r_evicted;
    assign o_evicted_point = r_ev_point;
    assign o_evicted_name  = r_ev_name;
    assign o_read_valid    = r_rd_valid;
    assign o_read_point    = r_rd_point;
    assign o_read_name     = r_rd_name;
    assign o_entry_count   = r_count;

`ifndef SYNTHESIS
    // Valid entries stay packed at the front
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MAX_ENTRIES'(1))) == '0)
        else $error("valid entries not packed at the front");

    // Fill count tracks the valid cells
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("fill count disagrees with valid cells");

    // A key is held by at most one cell
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_match))
        else $error("key matched in more than one cell");

    // An add always leaves its key at the front
    a_front_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_op == OP_ADD) |=> (w_front_point == $past(r_key)) && w_valid[0])
        else $error("added key not at the front");

    // A miss on a list with room grows it by one
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_op == OP_ADD && !w_hit && !w_full)
            |=> r_fill == $past(r_fill) + FILL_W'(1))
        else $error("fill count did not grow on a miss");
`endif

endmodule
